// ===== rtl/core/lrmp_pkg.sv =====
package lrmp_pkg;

  // Width of the result term on the output port.
  localparam int TERM_W = 3;

  // Step counter of the control program.
  typedef logic [3:0] step_t;

  // Datapath operation named by one control word.
  typedef enum logic [2:0] {
    OP_RED_Q,   // quotient estimate of every lane sum
    OP_RED_R,   // remainder of every lane sum, written back to the matrices
    OP_MUL,     // conditional acc*base and base*base into the lane sums
    OP_FIN,     // right-column sum of the accumulator into lane zero
    OP_OUT      // hand the term to the output register
  } op_t;

  // Sequencing rule of one control word.
  typedef enum logic [1:0] {
    JMP_NEXT,   // go on to the following step
    JMP_LOOP,   // back to the target while exponent bits remain
    JMP_END     // finish once the output register is free
  } jmp_t;

  // One control word of the program.
  typedef struct packed {
    op_t   op;
    logic  shift;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  // Control that the sequencer hands to the datapath.
  typedef struct packed {
    logic load;
    logic run;
    op_t  op;
    logic shift;
  } dp_ctl_t;

  localparam step_t LOOP_STEP = 4'd2;

  // Control program. Entering an item loads the lane sums, so the program
  // starts with the reduction of the coefficients.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{op: OP_OUT, shift: 1'b0, jmp: JMP_END, target: '0};
    unique case (step)
      4'd0: w = '{op: OP_RED_Q, shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd1: w = '{op: OP_RED_R, shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd2: w = '{op: OP_MUL,   shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd3: w = '{op: OP_RED_Q, shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd4: w = '{op: OP_RED_R, shift: 1'b1, jmp: JMP_LOOP, target: LOOP_STEP};
      4'd5: w = '{op: OP_FIN,   shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd6: w = '{op: OP_RED_Q, shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd7: w = '{op: OP_RED_R, shift: 1'b0, jmp: JMP_NEXT, target: '0};
      4'd8: w = '{op: OP_OUT,   shift: 1'b0, jmp: JMP_END,  target: '0};
      default: w = '{op: OP_OUT, shift: 1'b0, jmp: JMP_END, target: '0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/lrmp_datapath.sv =====
module lrmp_datapath #(
  parameter int MODULUS    = 7,
  parameter int INDEX_BITS = 31
) (
  input  logic                         clk,
  input  lrmp_pkg::dp_ctl_t            ctl,
  input  logic [15:0]                  coef_a,
  input  logic [15:0]                  coef_b,
  input  logic [30:0]                  index,
  output logic                         ex_more,
  output logic [lrmp_pkg::TERM_W-1:0]  term
);
  import lrmp_pkg::*;

  localparam int MW    = (MODULUS > 2) ? $clog2(MODULUS) : 1;
  localparam int SW    = (2 * MW + 1 > 16) ? 2 * MW + 1 : 16;
  localparam int PW    = 2 * SW;
  localparam int RW    = MW + 2;
  localparam int XW    = INDEX_BITS;
  localparam int RECIP = (1 << SW) / MODULUS;
  localparam int LANES = 8;

  localparam logic [SW-1:0] RECIP_V = SW'(RECIP);
  localparam logic [RW-1:0] MOD1    = RW'(MODULUS);
  localparam logic [RW-1:0] MOD2    = RW'(2 * MODULUS);

  // Lanes 0..3 hold the accumulator, lanes 4..7 the base, row by row.
  logic [MW-1:0] ent [LANES];
  logic [SW-1:0] sum [LANES];
  logic [SW-1:0] quo [LANES];
  logic [XW-1:0] ex;

  logic [SW-1:0] sum_next [LANES];
  logic [SW-1:0] quo_next [LANES];
  logic [MW-1:0] rem_next [LANES];
  logic [XW-1:0] idx_m;

  function automatic logic [SW-1:0] dot2(input logic [MW-1:0] x0, input logic [MW-1:0] y0,
                                         input logic [MW-1:0] x1, input logic [MW-1:0] y1);
    return SW'(x0) * SW'(y0) + SW'(x1) * SW'(y1);
  endfunction

  assign idx_m   = XW'(index);
  assign ex_more = |ex[XW-1:1];
  assign term    = TERM_W'(ent[0]);

  // Lane sums for a matrix step; the accumulator takes the base only when
  // the current exponent bit is set.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum_next[i] = sum[i];
    end
    if (ctl.op == OP_MUL) begin
      if (ex[0]) begin
        sum_next[0] = dot2(ent[0], ent[4], ent[1], ent[6]);
        sum_next[1] = dot2(ent[0], ent[5], ent[1], ent[7]);
        sum_next[2] = dot2(ent[2], ent[4], ent[3], ent[6]);
        sum_next[3] = dot2(ent[2], ent[5], ent[3], ent[7]);
      end else begin
        for (int i = 0; i < 4; i++) begin
          sum_next[i] = SW'(ent[i]);
        end
      end
      sum_next[4] = dot2(ent[4], ent[4], ent[5], ent[6]);
      sum_next[5] = dot2(ent[4], ent[5], ent[5], ent[7]);
      sum_next[6] = dot2(ent[6], ent[4], ent[7], ent[6]);
      sum_next[7] = dot2(ent[6], ent[5], ent[7], ent[7]);
    end else if (ctl.op == OP_FIN) begin
      sum_next[0] = SW'(ent[1]) + SW'(ent[3]);
    end
  end

  // Reduction: quotient estimate by a scaled reciprocal, which falls short
  // by at most two, then remainder with up to two corrections.
  always_comb begin
    logic [PW-1:0] qp;
    logic [RW-1:0] r;
    for (int i = 0; i < LANES; i++) begin
      qp = PW'(sum[i]) * PW'(RECIP_V);
      quo_next[i] = qp[PW-1:SW];
      r = RW'(sum[i]) - RW'(quo[i]) * MOD1;
      if (r >= MOD2) begin
        r = r - MOD2;
      end else if (r >= MOD1) begin
        r = r - MOD1;
      end
      rem_next[i] = MW'(r);
    end
  end

  // Lane registers and the exponent shifter.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum[0] <= SW'(1);
      sum[1] <= '0;
      sum[2] <= '0;
      sum[3] <= SW'(1);
      sum[4] <= '0;
      sum[5] <= SW'(coef_b);
      sum[6] <= SW'(1);
      sum[7] <= SW'(coef_a);
      ex     <= (idx_m > XW'(2)) ? idx_m - XW'(2) : '0;
    end else if (ctl.run) begin
      for (int i = 0; i < LANES; i++) begin
        sum[i] <= sum_next[i];
      end
      if (ctl.op == OP_RED_Q) begin
        for (int i = 0; i < LANES; i++) begin
          quo[i] <= quo_next[i];
        end
      end
      if (ctl.op == OP_RED_R) begin
        for (int i = 0; i < LANES; i++) begin
          ent[i] <= rem_next[i];
        end
      end
      if (ctl.shift) begin
        ex <= ex >> 1;
      end
    end
  end

endmodule

// ===== rtl/core/linear_recurrence_matrix_pow_mod.sv =====
// Returns f(index) mod MODULUS for f(1) = f(2) = 1 and f(k) = a*f(k-1) + b*f(k-2),
// by square-and-multiply on the companion matrix [[0,b],[1,a]]. A short control
// program drives one matrix datapath whose eight lanes form both products of a
// step at once; each exponent bit takes the products, the reciprocal quotient
// and the remainder in turn, and the loop stops once no exponent bits remain.
// No new item is taken while one is in flight; the next is taken the cycle
// after its result is loaded into the output register. The result waits in
// that register, so a new item may enter while it has not yet been taken.
module linear_recurrence_matrix_pow_mod #(
  parameter int MODULUS    = 7,
  parameter int INDEX_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  coef_a,
  input  logic [15:0]                  coef_b,
  input  logic [30:0]                  index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lrmp_pkg::TERM_W-1:0]  term_value
);
  import lrmp_pkg::*;

  logic    busy;
  logic    busy_next;
  step_t   step;
  step_t   step_next;
  logic    out_load;
  ctrl_t   cw;
  dp_ctl_t dp_ctl;
  logic    ex_more;
  logic [TERM_W-1:0] term;

  assign cw       = ucode(step);
  assign in_ready = !busy;

  assign dp_ctl.load  = in_valid && in_ready;
  assign dp_ctl.run   = busy;
  assign dp_ctl.op    = cw.op;
  assign dp_ctl.shift = cw.shift;

  lrmp_datapath #(
    .MODULUS    (MODULUS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk     (clk),
    .ctl     (dp_ctl),
    .coef_a  (coef_a),
    .coef_b  (coef_b),
    .index   (index),
    .ex_more (ex_more),
    .term    (term)
  );

  // Sequencer: step counter with the jump rule of the current control word.
  always_comb begin
    busy_next = busy;
    step_next = step;
    out_load  = 1'b0;
    if (!busy) begin
      if (in_valid) begin
        busy_next = 1'b1;
        step_next = '0;
      end
    end else begin
      unique case (cw.jmp)
        JMP_NEXT: step_next = step + 4'd1;
        JMP_LOOP: step_next = ex_more ? cw.target : step + 4'd1;
        JMP_END: begin
          if (!out_valid || out_ready) begin
            out_load  = 1'b1;
            busy_next = 1'b0;
            step_next = '0;
          end
        end
        default: step_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  // Output register; a waiting result is replaced only after its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      term_value <= term;
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrmp_pkg::*;

  localparam int MODULUS      = 7;
  localparam int INDEX_BITS   = 31;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 110;

  // 2x2 matrix over the integers mod MODULUS.
  typedef struct {
    int unsigned m00;
    int unsigned m01;
    int unsigned m10;
    int unsigned m11;
  } mat2_t;

  // One accepted request and the term it must produce.
  typedef struct {
    logic [15:0]       a;
    logic [15:0]       b;
    logic [30:0]       idx;
    logic [TERM_W-1:0] term;
  } term_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       coef_a = '0;
  logic [15:0]       coef_b = '0;
  logic [30:0]       index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TERM_W-1:0] term_value;

  bit                idle_on = 1'b1;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       out_stall_left = 0;
  term_req_t         pending_terms[$];

  linear_recurrence_matrix_pow_mod #(
    .MODULUS    (MODULUS),
    .INDEX_BITS (INDEX_BITS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .index      (index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .term_value (term_value)
  );

  // Free-running clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Product of two matrices with every entry reduced.
  function automatic mat2_t mat_mul_mod(input mat2_t x, input mat2_t y);
    mat2_t r;
    r.m00 = (x.m00 * y.m00 + x.m01 * y.m10) % MODULUS;
    r.m01 = (x.m00 * y.m01 + x.m01 * y.m11) % MODULUS;
    r.m10 = (x.m10 * y.m00 + x.m11 * y.m10) % MODULUS;
    r.m11 = (x.m10 * y.m01 + x.m11 * y.m11) % MODULUS;
    return r;
  endfunction

  // Term of the recurrence at idx, by powers of the companion matrix.
  function automatic logic [TERM_W-1:0] predict_term(input logic [15:0] a,
                                                     input logic [15:0] b,
                                                     input logic [30:0] idx);
    mat2_t           base;
    mat2_t           acc;
    longint unsigned ex;
    int unsigned     term;
    if (idx <= 31'd2) begin
      term = 1 % MODULUS;
    end else begin
      ex = longint'(idx) - 2;
      base.m00 = 0;
      base.m01 = b % MODULUS;
      base.m10 = 1;
      base.m11 = a % MODULUS;
      acc.m00 = 1;
      acc.m01 = 0;
      acc.m10 = 0;
      acc.m11 = 1;
      for (int i = 0; i < INDEX_BITS; i++) begin
        if (ex[i]) begin
          acc = mat_mul_mod(acc, base);
        end
        base = mat_mul_mod(base, base);
      end
      term = (acc.m01 + acc.m11) % MODULUS;
    end
    return term[TERM_W-1:0];
  endfunction

  // Result side: random stall bursts while idling is on.
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ready = 1'b0;
      out_stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready = 1'b0;
      out_stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Score every result transfer against the oldest request, then record new requests.
  always @(posedge clk) begin : score
    term_req_t head;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_terms.size() == 0) begin
          $display("%0t: unexpected result, expected none actual term_value=%0d",
                   $time, term_value);
          mismatches++;
        end else begin
          head = pending_terms.pop_front();
          if (term_value !== head.term) begin
            $display("%0t: term_value mismatch (a=%0d b=%0d index=%0d), expected %0d actual %0d",
                     $time, head.a, head.b, head.idx, head.term, term_value);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_terms.push_back('{a: coef_a, b: coef_b, idx: index,
                                  term: predict_term(coef_a, coef_b, index)});
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one request and hold it until its transfer; returns at that clock edge.
  task automatic send_item(input logic [15:0] a, input logic [15:0] b,
                           input logic [30:0] idx);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    coef_a   = a;
    coef_b   = b;
    index    = idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // First terms, including index zero, where the coefficients do not matter.
  task automatic test_short_index();
    send_item(16'hFFFF, 16'hFFFF, 31'd0);
    send_item(16'hFFFF, 16'hFFFF, 31'd1);
    send_item(16'h0000, 16'h0000, 31'd2);
    send_item(16'h0001, 16'h0001, 31'd3);
    send_item(16'h0001, 16'h0001, 31'd4);
    send_item(16'h0001, 16'h0001, 31'd5);
  endtask

  // Coefficients at and around multiples of the modulus and at the field limits.
  task automatic test_coef_extremes();
    send_item(16'h0000, 16'h0000, 31'd10);
    send_item(16'hFFFF, 16'hFFFF, 31'd10);
    send_item(16'h0007, 16'h0007, 31'd10);
    send_item(16'h0006, 16'h0006, 31'd10);
    send_item(16'h0008, 16'hFFFE, 31'd10);
    send_item(16'h0001, 16'h0000, 31'd10);
    send_item(16'h0000, 16'h0001, 31'd10);
  endtask

  // Long indices, most of them using the full width of the index.
  task automatic test_long_index();
    send_item(16'h0001, 16'h0001, 31'h7FFF_FFFF);
    send_item(16'hFFFF, 16'h0000, 31'h7FFF_FFFF);
    send_item(16'h0006, 16'h0005, 31'h7FFF_FFFE);
    send_item(16'h0003, 16'h0004, 31'h4000_0001);
    send_item(16'h0002, 16'h0003, 31'h4000_0002);
    send_item(16'h0005, 16'h0002, 31'h0010_0002);
  endtask

  // Random requests: half short indices, a quarter of random bit length, a quarter full width.
  task automatic test_random(input int count);
    logic [15:0] a;
    logic [15:0] b;
    logic [30:0] idx;
    for (int n = 0; n < count; n++) begin
      a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 13)) : 16'($urandom());
      b = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 13)) : 16'($urandom());
      case ($urandom_range(0, 3))
        0, 1: idx = 31'($urandom_range(0, 40));
        2:    idx = 31'($urandom() >> $urandom_range(1, 31));
        default: idx = 31'($urandom());
      endcase
      send_item(a, b, idx);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_short_index();
    test_coef_extremes();
    test_long_index();
    test_random(1600);

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random(150);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lrmp_pkg.sv
rtl/core/lrmp_datapath.sv
rtl/core/linear_recurrence_matrix_pow_mod.sv
test/tb.sv
